// ===== src/swfr_pkg.sv =====
// Package: shared constants, beat types and controller/datapath interface types.
`default_nettype none

package swfr_pkg;

    // window size and derived widths
    localparam int WINDOW  = 3;
    localparam int SEQ_MOD = WINDOW + 1;
    localparam int SEQ_W   = $clog2(SEQ_MOD);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PAY_W   = 32;

    // opcodes
    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_TX_NEW  = 3'd0;
    localparam logic [2:0] KIND_REFUSED = 3'd1;
    localparam logic [2:0] KIND_RETX    = 3'd2;
    localparam logic [2:0] KIND_ACK_OK  = 3'd3;
    localparam logic [2:0] KIND_ACK_BAD = 3'd4;
    localparam logic [2:0] KIND_EMPTY   = 3'd5;

    // timer actions
    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [PAY_W-1:0] payload_word;
        logic [SEQ_W-1:0] ack_number;
        logic             ack_checksum_ok;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]       result_kind;
        logic [SEQ_W-1:0] seq_number;
        logic [PAY_W-1:0] packet_payload;
        logic [1:0]       timer_action;
        logic             last_of_run;
    } t_out_beat;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_SEND,
        DP_REFUSE,
        DP_DROP,
        DP_ACK,
        DP_RESEND
    } t_dp_op;

    // controller -> datapath
    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] idx;
        logic [1:0]       timer;
        logic             last;
        logic             clr_dup;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0]       opcode;
        logic             send_full;
        logic             ack_ok;
        logic             dup_fire;
        logic [CNT_W-1:0] count;
    } t_dp_status;

    // sequence increment modulo SEQ_MOD (operand < SEQ_MOD)
    function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W:0]   k);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + k;
        if (s >= (SEQ_W+1)'(SEQ_MOD)) begin
            s = s - (SEQ_W+1)'(SEQ_MOD);
        end
        return s[SEQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/swfr_ctrl.sv =====
// Controller: decodes the latched beat and sequences datapath commands.
`default_nettype none

module swfr_ctrl
    import swfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RESEND
    } t_state;

    t_state           r_state;
    t_dp_cmd          r_cmd;
    logic [IDX_W-1:0] r_idx;

    logic             w_first_last;
    logic             w_idx_last;

    // first packet of a resend is also the last when at most one is buffered
    assign w_first_last = (i_status.count <= CNT_W'(1));
    assign w_idx_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == i_status.count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmd   <= '{op: DP_NONE, default: '0};
            r_idx   <= '0;
        end else begin
            r_cmd <= '{op: DP_NONE, default: '0};
            case (r_state)
                ST_IDLE: begin
                    if (i_accept) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_state <= ST_IDLE;
                    case (i_status.opcode)
                        OP_SEND: begin
                            r_cmd.op <= i_status.send_full ? DP_REFUSE : DP_SEND;
                        end
                        OP_ACK: begin
                            if (!i_status.ack_ok) begin
                                r_cmd.op <= DP_DROP;
                            end else if (i_status.dup_fire) begin
                                r_cmd.op      <= DP_RESEND;
                                r_cmd.idx     <= '0;
                                r_cmd.timer   <= TMR_NONE;
                                r_cmd.last    <= w_first_last;
                                r_cmd.clr_dup <= 1'b1;
                                r_idx         <= IDX_W'(1);
                                if (!w_first_last) begin
                                    r_state <= ST_RESEND;
                                end
                            end else begin
                                r_cmd.op <= DP_ACK;
                            end
                        end
                        OP_TIMEOUT: begin
                            r_cmd.op    <= DP_RESEND;
                            r_cmd.idx   <= '0;
                            r_cmd.timer <= TMR_RESTART;
                            r_cmd.last  <= w_first_last;
                            r_idx       <= IDX_W'(1);
                            if (!w_first_last) begin
                                r_state <= ST_RESEND;
                            end
                        end
                        default: begin
                            r_cmd.op <= DP_NONE;
                        end
                    endcase
                end
                ST_RESEND: begin
                    r_cmd.op    <= DP_RESEND;
                    r_cmd.idx   <= r_idx;
                    r_cmd.timer <= TMR_NONE;
                    r_cmd.last  <= w_idx_last;
                    r_idx       <= r_idx + IDX_W'(1);
                    if (w_idx_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cmd  = r_cmd;
    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ===== src/swfr_dp.sv =====
// Datapath: window store, sequence/ack state and result register.
`default_nettype none

module swfr_dp
    import swfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_beat i_in_beat,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_status    o_status,
    output logic          o_strobe,
    output t_out_beat     o_out_beat
);

    t_in_beat         r_in;
    logic [SEQ_W-1:0] r_seq [WINDOW];
    logic [PAY_W-1:0] r_pay [WINDOW];
    logic [CNT_W-1:0] r_count;
    logic [SEQ_W-1:0] r_base;
    logic [SEQ_W-1:0] r_next;
    logic [SEQ_W-1:0] r_last_ack;
    logic             r_ack_seen;
    logic [1:0]       r_dup;
    logic             r_strobe;
    t_out_beat        r_out;

    logic             w_found;
    logic [IDX_W-1:0] w_hit;
    logic             w_same_ack;
    logic [1:0]       w_dup_inc;
    logic [SEQ_W-1:0] w_new_base;
    logic [SEQ_W-1:0] n_seq [WINDOW];
    logic [PAY_W-1:0] n_pay [WINDOW];

    // first buffered entry matching the ack number
    always_comb begin
        w_found = 1'b0;
        w_hit   = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (!w_found && (CNT_W'(i) < r_count) && (r_seq[i] == r_in.ack_number)) begin
                w_found = 1'b1;
                w_hit   = IDX_W'(i);
            end
        end
    end

    // store contents after dropping entries 0..hit
    always_comb begin
        for (int j = 0; j < WINDOW; j++) begin
            n_seq[j] = r_seq[j];
            n_pay[j] = r_pay[j];
            for (int s = 0; s < WINDOW; s++) begin
                if (w_found && (s == j + int'(w_hit) + 1)) begin
                    n_seq[j] = r_seq[s];
                    n_pay[j] = r_pay[s];
                end
            end
        end
    end

    assign w_same_ack = r_ack_seen && (r_last_ack == r_in.ack_number);
    assign w_dup_inc  = r_dup + 2'd1;
    assign w_new_base = seq_add(r_in.ack_number, (SEQ_W+1)'(1));

    assign o_status.opcode    = r_in.opcode;
    assign o_status.send_full = (seq_add(r_base, (SEQ_W+1)'(WINDOW)) == r_next)
                                || (r_count >= CNT_W'(WINDOW));
    assign o_status.ack_ok    = r_in.ack_checksum_ok;
    assign o_status.dup_fire  = w_same_ack && (w_dup_inc == 2'd2);
    assign o_status.count     = r_count;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in <= i_in_beat;
        end
    end

    // window store, no reset: only written entries are read
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_SEND: begin
                r_seq[r_count[IDX_W-1:0]] <= r_next;
                r_pay[r_count[IDX_W-1:0]] <= r_in.payload_word;
            end
            DP_ACK: begin
                for (int j = 0; j < WINDOW; j++) begin
                    r_seq[j] <= n_seq[j];
                    r_pay[j] <= n_pay[j];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_base     <= '0;
            r_next     <= '0;
            r_last_ack <= '0;
            r_ack_seen <= 1'b0;
            r_dup      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (i_cmd.op)
                DP_SEND: begin
                    r_count  <= r_count + CNT_W'(1);
                    r_next   <= seq_add(r_next, (SEQ_W+1)'(1));
                    r_strobe <= 1'b1;
                end
                DP_REFUSE, DP_DROP: begin
                    r_strobe <= 1'b1;
                end
                DP_ACK: begin
                    if (w_same_ack) begin
                        r_dup <= w_dup_inc;
                    end else begin
                        r_last_ack <= r_in.ack_number;
                        r_ack_seen <= 1'b1;
                        r_dup      <= '0;
                    end
                    if (w_found) begin
                        r_count <= r_count - (CNT_W'(w_hit) + CNT_W'(1));
                    end
                    r_base   <= w_new_base;
                    r_strobe <= 1'b1;
                end
                DP_RESEND: begin
                    if (i_cmd.clr_dup) begin
                        r_dup <= '0;
                    end
                    r_strobe <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        r_out <= '0;
        r_out.last_of_run <= 1'b1;
        case (i_cmd.op)
            DP_SEND: begin
                r_out.result_kind    <= KIND_TX_NEW;
                r_out.seq_number     <= r_next;
                r_out.packet_payload <= r_in.payload_word;
                r_out.timer_action   <= (r_base == r_next) ? TMR_START : TMR_NONE;
            end
            DP_REFUSE: begin
                r_out.result_kind <= KIND_REFUSED;
            end
            DP_DROP: begin
                r_out.result_kind <= KIND_ACK_BAD;
            end
            DP_ACK: begin
                r_out.result_kind  <= KIND_ACK_OK;
                r_out.timer_action <= (w_new_base == r_next) ? TMR_STOP : TMR_RESTART;
            end
            DP_RESEND: begin
                r_out.timer_action <= i_cmd.timer;
                if (r_count == '0) begin
                    r_out.result_kind <= KIND_EMPTY;
                end else begin
                    r_out.result_kind    <= KIND_RETX;
                    r_out.seq_number     <= r_seq[i_cmd.idx];
                    r_out.packet_payload <= r_pay[i_cmd.idx];
                    r_out.last_of_run    <= i_cmd.last;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_strobe   = r_strobe;
    assign o_out_beat = r_out;

endmodule

`default_nettype wire

// ===== src/sliding_window_sender_fast_retransmit_unit.sv =====
// Top level: go-back-N sender with fast retransmit, controller plus datapath.
`default_nettype none

// Go-back-N sender, window of WINDOW packets, sequence numbers modulo
// WINDOW+1. A command beat is taken when start is high and busy is low;
// each result beat is shown for one cycle with o_strobe high and must be
// taken then, as the receiver has no way to stall. The command beat is
// registered, then the controller's command, then the result beat. Send,
// ack and dropped-ack commands give one result and busy is high for one
// cycle. A timeout or fast retransmit walks the window store one entry per
// cycle, with busy held until the last entry is issued (one result of kind
// "nothing buffered" when empty); no new command is taken while busy is
// high.
// Opcode 3 is a no-op: taken, no result. Timer action rides on the first
// result of a run only; last_of_run marks the final one. No clearing pass
// after reset: the window store is read only where it has been written.

module sliding_window_sender_fast_retransmit_unit
    import swfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_beat i_in_beat,
    output logic          busy,
    output logic          o_strobe,
    output t_out_beat     o_out_beat
);

    logic       w_accept;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign w_accept = start && !busy;

    // sequencing: decide, then one command per result beat
    swfr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // window state and registered result beat
    swfr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_in_beat  (i_in_beat),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_strobe   (o_strobe),
        .o_out_beat (o_out_beat)
    );

endmodule

`default_nettype wire

// ===== src/swfr_checker.sv =====
// Checker: port-level assertions on the sender, bound to the top level.
`default_nettype none

module swfr_checker
    import swfr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_strobe,
    input wire t_out_beat o_out_beat
);

    // a result beat always follows an earlier busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy, 2))
        else $error("result beat without preceding busy cycle");

    // a taken command makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // only retransmit beats may be non-final
    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_out_beat.result_kind != KIND_RETX)) |-> o_out_beat.last_of_run)
        else $error("non-retransmit beat not marked last");

    // a run continues without gaps
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out_beat.last_of_run) |=> o_strobe)
        else $error("gap inside a retransmit run");

    // packet fields are zero on non-packet beats
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_out_beat.result_kind != KIND_TX_NEW)
                  && (o_out_beat.result_kind != KIND_RETX))
        |-> ((o_out_beat.seq_number == '0) && (o_out_beat.packet_payload == '0)))
        else $error("packet fields set on non-packet beat");

endmodule

bind sliding_window_sender_fast_retransmit_unit swfr_checker u_swfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_out_beat (o_out_beat)
);

`default_nettype wire

// ===== dv/swfr_window_checker.sv =====
// Checker for the go-back-N sender: watches command and result beats and predicts the results.
`timescale 1ns / 1ps

module swfr_window_checker
    import swfr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire logic      i_busy,
    input  wire t_in_beat  i_cmd_beat,
    input  wire logic      i_strobe,
    input  wire t_out_beat i_res_beat,
    output int             o_err_count,
    output int             o_pending,
    output int             o_beats_checked
);

    // result beats owed by the block, oldest first
    t_out_beat due_beats[$];

    // shadow of the sender's window
    logic [SEQ_W-1:0] held_seq [WINDOW];
    logic [PAY_W-1:0] held_pay [WINDOW];
    int               held_n;
    logic [SEQ_W-1:0] base_seq;
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] prev_ack;
    logic             prev_ack_valid;
    logic [1:0]       dup_run;

    initial begin
        o_err_count     = 0;
        o_pending       = 0;
        o_beats_checked = 0;
        held_n          = 0;
        base_seq        = '0;
        next_seq        = '0;
        prev_ack        = '0;
        prev_ack_valid  = 1'b0;
        dup_run         = '0;
    end

    function automatic t_out_beat make_beat(logic [2:0] kind, logic [SEQ_W-1:0] seq,
                                            logic [PAY_W-1:0] pay, logic [1:0] tmr,
                                            logic last);
        t_out_beat b;
        b.result_kind    = kind;
        b.seq_number     = seq;
        b.packet_payload = pay;
        b.timer_action   = tmr;
        b.last_of_run    = last;
        return b;
    endfunction

    // queue a beat at the tail of the owed list
    function automatic void owe_beat(input t_out_beat b);
        due_beats = {due_beats, b};
    endfunction

    // go-back-N resend of every buffered packet, timer action on the first beat
    task automatic resend_window(input logic [1:0] tmr);
        if (held_n == 0) begin
            owe_beat(make_beat(KIND_EMPTY, '0, '0, tmr, 1'b1));
        end else begin
            for (int i = 0; i < held_n; i++) begin
                owe_beat(make_beat(KIND_RETX, held_seq[i], held_pay[i],
                                   (i == 0) ? tmr : TMR_NONE,
                                   (i + 1 == held_n)));
            end
        end
    endtask

    task automatic predict_window_step(input t_in_beat cmd);
        int  hit;
        int  drop;
        bit  fire;
        case (cmd.opcode)
            OP_SEND: begin
                if ((int'(base_seq) + WINDOW) % SEQ_MOD == int'(next_seq) ||
                    held_n >= WINDOW) begin
                    owe_beat(make_beat(KIND_REFUSED, '0, '0, TMR_NONE, 1'b1));
                end else begin
                    held_seq[held_n] = next_seq;
                    held_pay[held_n] = cmd.payload_word;
                    held_n++;
                    owe_beat(make_beat(KIND_TX_NEW, next_seq, cmd.payload_word,
                                       (base_seq == next_seq) ? TMR_START : TMR_NONE,
                                       1'b1));
                    next_seq = SEQ_W'((int'(next_seq) + 1) % SEQ_MOD);
                end
            end
            OP_ACK: begin
                if (!cmd.ack_checksum_ok) begin
                    owe_beat(make_beat(KIND_ACK_BAD, '0, '0, TMR_NONE, 1'b1));
                end else begin
                    fire = 1'b0;
                    if (prev_ack_valid && prev_ack == cmd.ack_number) begin
                        dup_run = dup_run + 2'd1;
                        if (dup_run == 2'd2) begin
                            dup_run = '0;
                            fire    = 1'b1;
                        end
                    end else begin
                        prev_ack       = cmd.ack_number;
                        prev_ack_valid = 1'b1;
                        dup_run        = '0;
                    end
                    if (fire) begin
                        resend_window(TMR_NONE);
                    end else begin
                        hit = -1;
                        for (int i = 0; i < held_n; i++) begin
                            if (hit < 0 && held_seq[i] == cmd.ack_number) begin
                                hit = i;
                            end
                        end
                        // cumulative ack: drop everything up to and including the hit
                        if (hit >= 0) begin
                            drop = hit + 1;
                            for (int i = 0; i + drop < held_n; i++) begin
                                held_seq[i] = held_seq[i + drop];
                                held_pay[i] = held_pay[i + drop];
                            end
                            held_n -= drop;
                        end
                        base_seq = SEQ_W'((int'(cmd.ack_number) + 1) % SEQ_MOD);
                        owe_beat(make_beat(KIND_ACK_OK, '0, '0,
                                           (base_seq == next_seq) ? TMR_STOP
                                                                  : TMR_RESTART,
                                           1'b1));
                    end
                end
            end
            OP_TIMEOUT: resend_window(TMR_RESTART);
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [PAY_W-1:0] want,
                               input logic [PAY_W-1:0] got);
        if (want !== got) begin
            o_err_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // results are compared before the same edge's command is predicted;
    // a command's first result is never due on its own accepting edge
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (i_strobe) begin
                o_beats_checked++;
                if (due_beats.size() == 0) begin
                    o_err_count++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, i_res_beat);
                end else begin
                    want = due_beats[0];
                    due_beats.delete(0);
                    check_field("result_kind", PAY_W'(want.result_kind),
                                PAY_W'(i_res_beat.result_kind));
                    check_field("seq_number", PAY_W'(want.seq_number),
                                PAY_W'(i_res_beat.seq_number));
                    check_field("packet_payload", want.packet_payload,
                                i_res_beat.packet_payload);
                    check_field("timer_action", PAY_W'(want.timer_action),
                                PAY_W'(i_res_beat.timer_action));
                    check_field("last_of_run", PAY_W'(want.last_of_run),
                                PAY_W'(i_res_beat.last_of_run));
                end
            end
            if (i_start && !i_busy) begin
                predict_window_step(i_cmd_beat);
            end
        end
        o_pending = due_beats.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: clock, reset and command stimulus for the go-back-N sender.
`timescale 1ns / 1ps

module tb_top;
    import swfr_pkg::*;

    // the package names no code for the spare opcode; the block takes it and says nothing
    localparam logic [1:0] OP_NOOP = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      start;
    t_in_beat  cmd_beat;
    logic      busy;
    logic      strobe;
    t_out_beat res_beat;

    int err_count;
    int pending;
    int beats_checked;

    // stimulus bookkeeping
    int op_tally [4];
    int counted_cmds;    // commands that the block acts on (no-ops left out)
    int burst_left;
    logic [1:0] last_ack_sent;

    sliding_window_sender_fast_retransmit_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .i_in_beat  (cmd_beat),
        .busy       (busy),
        .o_strobe   (strobe),
        .o_out_beat (res_beat)
    );

    swfr_window_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd_beat      (cmd_beat),
        .i_strobe        (strobe),
        .i_res_beat      (res_beat),
        .o_err_count     (err_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog: far beyond the slowest legal run (~430 beats)
    initial begin
        #400us;
        $display("%0t: watchdog expired, %0d result beats still owed", $time, pending);
        $display("tb_top: errors");
        $finish;
    end

    // Present one command beat at the falling edge and hold it until the block
    // takes it (start high while busy low at a rising edge). Between bursts the
    // line goes quiet for a random number of cycles; within a burst the next
    // beat follows straight on, so start stays high with no glitch.
    task automatic push_command(input logic [1:0] op, input logic [PAY_W-1:0] pay,
                                input logic [SEQ_W-1:0] ack, input logic ok);
        int gap;
        @(negedge clk);
        start                    = 1'b1;
        cmd_beat.opcode          = op;
        cmd_beat.payload_word    = pay;
        cmd_beat.ack_number      = ack;
        cmd_beat.ack_checksum_ok = ok;
        @(posedge clk);
        while (busy) begin
            @(posedge clk);
        end
        op_tally[op]++;
        if (op != OP_NOOP) begin
            counted_cmds++;
        end
        if (op == OP_ACK && ok) begin
            last_ack_sent = ack;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            // roughly a third of bursts run straight into the next one
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Hold off until every owed result has come, then a few more cycles so a
    // trailing no-op or a stray beat would still show up.
    task automatic drain_results;
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // One random piece of traffic. Most of it is well-formed: windows filled
    // by runs of sends, cumulative acks, runs of repeated acks that can fire the
    // fast retransmit, and timeouts. The rest is corrupt acks and no-ops.
    task automatic random_traffic;
        int pick;
        int n;
        logic [1:0] dup_num;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            n = $urandom_range(1, 4);
            repeat (n) push_command(OP_SEND, $urandom, 2'($urandom_range(0, 3)),
                                    1'($urandom_range(0, 1)));
        end else if (pick < 58) begin
            push_command(OP_ACK, $urandom, 2'($urandom_range(0, 3)), 1'b1);
        end else if (pick < 74) begin
            // duplicate run, half the time on the last good ack so the count carries on
            dup_num = ($urandom_range(0, 1) == 0) ? last_ack_sent
                                                  : 2'($urandom_range(0, 3));
            n = $urandom_range(2, 3);
            repeat (n) push_command(OP_ACK, $urandom, dup_num, 1'b1);
        end else if (pick < 85) begin
            push_command(OP_TIMEOUT, $urandom, 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)));
        end else if (pick < 94) begin
            push_command(OP_ACK, $urandom, 2'($urandom_range(0, 3)), 1'b0);
        end else begin
            push_command(OP_NOOP, $urandom, 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int random_start;
        int next_pause;

        start         = 1'b0;
        cmd_beat      = '0;
        rst_n         = 1'b0;
        counted_cmds  = 0;
        burst_left    = 0;
        last_ack_sent = '0;
        foreach (op_tally[i]) op_tally[i] = 0;

        // synchronous reset, released on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed ---
        push_command(OP_NOOP,    32'h0000_0000, 2'd0, 1'b0); // spare opcode: no result
        push_command(OP_TIMEOUT, 32'h0000_0000, 2'd0, 1'b1); // timeout, empty window
        push_command(OP_ACK,     32'h0000_0000, 2'd0, 1'b0); // corrupt ack dropped
        push_command(OP_ACK,     32'h0000_0000, 2'd0, 1'b1); // unknown ack moves base
        push_command(OP_SEND,    32'h1234_5678, 2'd0, 1'b0); // refused: base now ahead
        push_command(OP_ACK,     32'h0000_0000, 2'd0, 1'b1); // first duplicate
        push_command(OP_ACK,     32'h0000_0000, 2'd0, 1'b1); // fast retransmit, empty
        push_command(OP_ACK,     32'hFFFF_FFFF, 2'd3, 1'b1); // realign base, timer stop
        push_command(OP_SEND,    32'h0000_0000, 2'd3, 1'b1); // seq 0, timer start
        push_command(OP_SEND,    32'hFFFF_FFFF, 2'd0, 1'b0); // seq 1
        push_command(OP_SEND,    32'hA5A5_A5A5, 2'd1, 1'b1); // seq 2, window full
        push_command(OP_SEND,    32'h5A5A_5A5A, 2'd2, 1'b0); // refused: full window
        push_command(OP_TIMEOUT, 32'hFFFF_FFFF, 2'd3, 1'b0); // resend all three
        push_command(OP_ACK,     32'h0000_0000, 2'd0, 1'b1); // drops one, restart
        push_command(OP_ACK,     32'h0000_0000, 2'd0, 1'b1); // duplicate
        push_command(OP_ACK,     32'h0000_0000, 2'd0, 1'b1); // fast retransmit of two
        push_command(OP_ACK,     32'h0000_0000, 2'd2, 1'b1); // clears window, stop
        push_command(OP_SEND,    32'hFFFF_FFFF, 2'd3, 1'b1); // seq 3 wraps next
        push_command(OP_ACK,     32'hFFFF_FFFF, 2'd3, 1'b0); // corrupt ack, max number
        push_command(OP_ACK,     32'h0000_0000, 2'd1, 1'b1); // unbuffered ack number
        push_command(OP_TIMEOUT, 32'h0000_0000, 2'd0, 1'b1); // resend the one left
        drain_results();

        // --- random ---
        random_start = counted_cmds;
        next_pause   = counted_cmds + 100;
        while (counted_cmds - random_start < 400) begin
            random_traffic();
            // sender holds off now and then until everything owed is back
            if (counted_cmds >= next_pause) begin
                drain_results();
                next_pause = counted_cmds + $urandom_range(60, 140);
            end
        end
        drain_results();

        $display("Run covered %0d commands: %0d sends, %0d acks, %0d timeouts, %0d no-ops",
                 op_tally[OP_SEND] + op_tally[OP_ACK] + op_tally[OP_TIMEOUT] + op_tally[OP_NOOP],
                 op_tally[OP_SEND], op_tally[OP_ACK], op_tally[OP_TIMEOUT], op_tally[OP_NOOP]);
        $display("%0d result beats compared field by field, %0d mismatches",
                 beats_checked, err_count);
        if (pending != 0) begin
            $display("%0t: %0d result beats never arrived", $time, pending);
        end
        if (err_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
